// ===== hdl/aesa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aesa_pkg;

    // fixed field widths
    localparam int ACT_W      = 6;
    localparam int ACTIVITIES = 64;
    localparam int EDGE_W     = 2 * ACT_W;
    localparam int CNT_W      = 48;
    localparam int WEIGHT_W   = 32;
    localparam int SERIAL_W   = 32;
    localparam int TALLY_W    = 13;
    localparam int OP_W       = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_ACT   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_EDGE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

    typedef logic [CNT_W-1:0] t_count;

    // one activity memory row
    typedef struct packed {
        t_count                total;
        t_count                case_total;
        t_count                start_total;
        t_count                end_total;
        logic [SERIAL_W-1:0]   last_serial;
    } t_act_entry;

    // one edge memory row
    typedef struct packed {
        logic                  seen;
        t_count                total;
        t_count                case_total;
        logic [SERIAL_W-1:0]   last_serial;
    } t_edge_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic lookup;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
    } t_status;

    // saturating add of a weight onto a counter
    function automatic t_count sat_add(input t_count a, input logic [WEIGHT_W-1:0] w);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W + 1 - WEIGHT_W){1'b0}}, w};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/activity_edge_stats_accumulator.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-----------------------------------------
// command   | in        | start, busy            | opcode, act_id, weight, first/last
//           |           |                        | marks, edge_target
// result    | out       | o_strobe (one cycle)   | occurrences, case/start/end occurrences,
//           |           |                        | distinct_edges, total_weight
// config    | in        | i_cfg_wr_en            | i_cfg_wr_data (edges enabled)
//
// every accepted word passes through capture, memory lookup and read-modify-write;
// a word with the unused opcode is dropped at capture.
// a read's result word shows on the result ports in the cycle after the write-back.
// after reset busy stays high while the edge and activity memories are swept to zero,
// one row a cycle through each memory's single write port.
// results cannot be held off by the receiver; the strobe is high for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module activity_edge_stats_accumulator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [aesa_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [aesa_pkg::ACT_W-1:0]    i_act_id,
    input  wire logic [aesa_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                          i_first_of_variant,
    input  wire logic                          i_last_of_variant,
    input  wire logic [aesa_pkg::ACT_W-1:0]    i_edge_target,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic                          i_cfg_wr_data,
    output logic                               o_strobe,
    output logic [aesa_pkg::CNT_W-1:0]         o_occurrences,
    output logic [aesa_pkg::CNT_W-1:0]         o_case_occurrences,
    output logic [aesa_pkg::CNT_W-1:0]         o_start_occurrences,
    output logic [aesa_pkg::CNT_W-1:0]         o_end_occurrences,
    output logic [aesa_pkg::TALLY_W-1:0]       o_distinct_edges,
    output logic [aesa_pkg::CNT_W-1:0]         o_total_weight
);
    import aesa_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing
    aesa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // counter memories and arithmetic
    aesa_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_opcode            (i_opcode),
        .i_act_id            (i_act_id),
        .i_weight            (i_weight),
        .i_first_of_variant  (i_first_of_variant),
        .i_last_of_variant   (i_last_of_variant),
        .i_edge_target       (i_edge_target),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .o_strobe            (o_strobe),
        .o_occurrences       (o_occurrences),
        .o_case_occurrences  (o_case_occurrences),
        .o_start_occurrences (o_start_occurrences),
        .o_end_occurrences   (o_end_occurrences),
        .o_distinct_edges    (o_distinct_edges),
        .o_total_weight      (o_total_weight)
    );

endmodule

`default_nettype wire

// ===== hdl/aesa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aesa_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    input  wire logic [aesa_pkg::OP_W-1:0] i_opcode,
    input  wire aesa_pkg::t_status        i_status,
    output aesa_pkg::t_cmd                o_cmd,
    output logic                          busy
);
    import aesa_pkg::*;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_LOOKUP = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign accept = (r_state == S_IDLE) && start;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && (i_opcode != OP_NONE)) n_state = S_LOOKUP;
            end
            S_LOOKUP: n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    always_comb begin
        o_cmd.capture = accept;
        o_cmd.clear   = (r_state == S_CLEAR);
        o_cmd.lookup  = (r_state == S_LOOKUP);
        o_cmd.commit  = (r_state == S_COMMIT);
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/aesa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aesa_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire aesa_pkg::t_cmd                i_cmd,
    output aesa_pkg::t_status                  o_status,
    input  wire logic [aesa_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [aesa_pkg::ACT_W-1:0]    i_act_id,
    input  wire logic [aesa_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                          i_first_of_variant,
    input  wire logic                          i_last_of_variant,
    input  wire logic [aesa_pkg::ACT_W-1:0]    i_edge_target,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic                          i_cfg_wr_data,
    output logic                               o_strobe,
    output logic [aesa_pkg::CNT_W-1:0]         o_occurrences,
    output logic [aesa_pkg::CNT_W-1:0]         o_case_occurrences,
    output logic [aesa_pkg::CNT_W-1:0]         o_start_occurrences,
    output logic [aesa_pkg::CNT_W-1:0]         o_end_occurrences,
    output logic [aesa_pkg::TALLY_W-1:0]       o_distinct_edges,
    output logic [aesa_pkg::CNT_W-1:0]         o_total_weight
);
    import aesa_pkg::*;

    // captured word
    logic [OP_W-1:0]     r_op;
    logic [ACT_W-1:0]    r_id;
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_first;
    logic                r_last;
    logic [ACT_W-1:0]    r_tgt;

    // scalar state
    logic                r_edges_en;
    logic [ACT_W-1:0]    r_prev;
    logic [SERIAL_W-1:0] r_serial;
    logic [SERIAL_W-1:0] n_serial;
    t_count              r_sum;
    logic [TALLY_W-1:0]  r_tally;
    logic [EDGE_W-1:0]   r_clr_addr;

    // memories and registered read data
    t_act_entry          act_mem [ACTIVITIES];
    t_edge_entry         edge_mem [ACTIVITIES * ACTIVITIES];
    t_act_entry          r_act_rd;
    t_edge_entry         r_edge_rd;
    logic [EDGE_W-1:0]   edge_rd_addr;
    logic [EDGE_W-1:0]   r_edge_addr;
    logic                r_edge_hit;

    // write-back
    logic                is_acc;
    logic                act_we;
    logic                edge_we;
    logic [ACT_W-1:0]    act_wa;
    logic [EDGE_W-1:0]   edge_wa;
    t_act_entry          act_wd;
    t_edge_entry         edge_wd;
    t_act_entry          act_upd;
    t_edge_entry         edge_upd;

    // capture accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_id     <= i_act_id;
            r_weight <= i_weight;
            r_first  <= i_first_of_variant;
            r_last   <= i_last_of_variant;
            r_tgt    <= i_edge_target;
        end
    end

    assign is_acc = (r_op == OP_ACCUMULATE);

    // serial advance, skipping zero on wrap
    always_comb begin
        n_serial = r_serial + SERIAL_W'(1);
        if (n_serial == '0) n_serial = SERIAL_W'(1);
    end

    // edge address: read source/target, or previous/current for an element
    assign edge_rd_addr = (r_op == OP_READ_EDGE) ? {r_id, r_tgt} : {r_prev, r_id};

    // clearing sweep
    assign o_status.clear_done = (r_clr_addr == {EDGE_W{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !o_status.clear_done) begin
            r_clr_addr <= r_clr_addr + EDGE_W'(1);
        end
    end

    // lookup stage: edge address, serial and weight sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_edge_addr <= edge_rd_addr;
            r_edge_hit  <= is_acc && !r_first && (r_edges_en || (r_prev == r_id));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial <= '0;
            r_sum    <= '0;
        end else if (i_cmd.lookup && is_acc && r_first) begin
            r_serial <= n_serial;
            r_sum    <= sat_add(r_sum, r_weight);
        end
    end

    // updated activity row
    always_comb begin
        act_upd       = r_act_rd;
        act_upd.total = sat_add(r_act_rd.total, r_weight);
        if (r_act_rd.last_serial != r_serial) begin
            act_upd.case_total  = sat_add(r_act_rd.case_total, r_weight);
            act_upd.last_serial = r_serial;
        end
        if (r_first) act_upd.start_total = sat_add(r_act_rd.start_total, r_weight);
        if (r_last)  act_upd.end_total   = sat_add(r_act_rd.end_total, r_weight);
    end

    // updated edge row
    always_comb begin
        edge_upd       = r_edge_rd;
        edge_upd.seen  = 1'b1;
        edge_upd.total = sat_add(r_edge_rd.total, r_weight);
        if (r_edge_rd.last_serial != r_serial) begin
            edge_upd.case_total  = sat_add(r_edge_rd.case_total, r_weight);
            edge_upd.last_serial = r_serial;
        end
    end

    // write port selection: sweep zeros, or commit the update
    always_comb begin
        act_we  = i_cmd.clear || (i_cmd.commit && is_acc);
        edge_we = i_cmd.clear || (i_cmd.commit && r_edge_hit);
        act_wa  = i_cmd.clear ? r_clr_addr[ACT_W-1:0] : r_id;
        edge_wa = i_cmd.clear ? r_clr_addr : r_edge_addr;
        act_wd  = i_cmd.clear ? '0 : act_upd;
        edge_wd = i_cmd.clear ? '0 : edge_upd;
    end

    // activity memory
    always_ff @(posedge i_clk) begin
        if (act_we) act_mem[act_wa] <= act_wd;
        if (i_cmd.lookup) r_act_rd <= act_mem[r_id];
    end

    // edge memory
    always_ff @(posedge i_clk) begin
        if (edge_we) edge_mem[edge_wa] <= edge_wd;
        if (i_cmd.lookup) r_edge_rd <= edge_mem[edge_rd_addr];
    end

    // previous activity, distinct edge tally, edge enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_tally    <= '0;
            r_edges_en <= 1'b1;
        end else begin
            if (i_cfg_wr_en) r_edges_en <= i_cfg_wr_data;
            if (i_cmd.commit && is_acc) r_prev <= r_id;
            if (i_cmd.commit && r_edge_hit && !r_edge_rd.seen
                && (r_tally != {TALLY_W{1'b1}})) begin
                r_tally <= r_tally + TALLY_W'(1);
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.commit && !is_acc;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_distinct_edges <= r_tally;
            o_total_weight   <= r_sum;
            if (r_op == OP_READ_EDGE) begin
                o_occurrences       <= r_edge_rd.total;
                o_case_occurrences  <= r_edge_rd.case_total;
                o_start_occurrences <= '0;
                o_end_occurrences   <= '0;
            end else begin
                o_occurrences       <= r_act_rd.total;
                o_case_occurrences  <= r_act_rd.case_total;
                o_start_occurrences <= r_act_rd.start_total;
                o_end_occurrences   <= r_act_rd.end_total;
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_activity_edge_stats_accumulator.sv =====
`timescale 1ns / 1ps

module tb_activity_edge_stats_accumulator;
    import aesa_pkg::*;

    localparam int EDGE_COUNT = ACTIVITIES * ACTIVITIES;
    localparam bit [CNT_W-1:0] COUNT_MAX = '1;
    localparam bit [TALLY_W-1:0] TALLY_MAX = '1;

    // one read-out word as seen on the result ports
    typedef struct packed {
        t_count             occ;
        t_count             case_occ;
        t_count             start_occ;
        t_count             end_occ;
        logic [TALLY_W-1:0] distinct;
        t_count             total;
    } t_readout;

    // running activity and edge counts, plus the read-outs still owed by the block
    class follows_counts;
        bit [CNT_W-1:0]    act_total[ACTIVITIES];
        bit [CNT_W-1:0]    act_case[ACTIVITIES];
        bit [CNT_W-1:0]    act_start[ACTIVITIES];
        bit [CNT_W-1:0]    act_end[ACTIVITIES];
        bit [SERIAL_W-1:0] act_serial[ACTIVITIES];
        bit [CNT_W-1:0]    edge_total[EDGE_COUNT];
        bit [CNT_W-1:0]    edge_case[EDGE_COUNT];
        bit [SERIAL_W-1:0] edge_serial[EDGE_COUNT];
        bit                edge_seen[EDGE_COUNT];
        bit [ACT_W-1:0]    prev_act;
        bit [SERIAL_W-1:0] serial;
        bit [CNT_W-1:0]    weight_sum;
        bit [TALLY_W-1:0]  tally;
        bit                edges_on;
        t_readout          pending_readouts[$];
        int                mismatch_count;

        function new();
            edges_on = 1'b1;
            mismatch_count = 0;
        endfunction

        // counters stick at all ones
        function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] acc, bit [WEIGHT_W-1:0] w);
            if (acc > COUNT_MAX - CNT_W'(w))
                return COUNT_MAX;
            return acc + CNT_W'(w);
        endfunction

        // update the counts for one accepted word, queue its read-out if any
        function void apply_word(logic [OP_W-1:0] op, logic [ACT_W-1:0] id,
                                 logic [WEIGHT_W-1:0] w, bit first, bit last,
                                 logic [ACT_W-1:0] tgt);
            bit [EDGE_W-1:0] e;
            t_readout        r;
            r = '0;
            case (op)
                OP_ACCUMULATE: begin
                    // a first element opens a new variant serial, never zero
                    if (first) begin
                        serial = serial + 1'b1;
                        if (serial == 0)
                            serial = 1;
                        weight_sum = bump(weight_sum, w);
                    end
                    act_total[id] = bump(act_total[id], w);
                    if (act_serial[id] != serial) begin
                        act_case[id] = bump(act_case[id], w);
                        act_serial[id] = serial;
                    end
                    if (first)
                        act_start[id] = bump(act_start[id], w);
                    if (last)
                        act_end[id] = bump(act_end[id], w);
                    // edge from the previous element, self-loops only when edges are off
                    if (!first && (edges_on || prev_act == id)) begin
                        e = {prev_act, id};
                        if (!edge_seen[e]) begin
                            edge_seen[e] = 1'b1;
                            if (tally != TALLY_MAX)
                                tally = tally + 1'b1;
                        end
                        edge_total[e] = bump(edge_total[e], w);
                        if (edge_serial[e] != serial) begin
                            edge_case[e] = bump(edge_case[e], w);
                            edge_serial[e] = serial;
                        end
                    end
                    prev_act = id;
                end
                OP_READ_ACT: begin
                    r.occ = act_total[id];
                    r.case_occ = act_case[id];
                    r.start_occ = act_start[id];
                    r.end_occ = act_end[id];
                    r.distinct = tally;
                    r.total = weight_sum;
                    pending_readouts.push_back(r);
                end
                OP_READ_EDGE: begin
                    e = {id, tgt};
                    r.occ = edge_total[e];
                    r.case_occ = edge_case[e];
                    r.distinct = tally;
                    r.total = weight_sum;
                    pending_readouts.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // compare one read-out word against the oldest one owed
        function void compare_readout(t_readout got);
            t_readout want;
            if (pending_readouts.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, actual %p",
                         $time, got);
                return;
            end
            want = pending_readouts.pop_front();
            field_check("occurrences", 64'(want.occ), 64'(got.occ));
            field_check("case_occurrences", 64'(want.case_occ), 64'(got.case_occ));
            field_check("start_occurrences", 64'(want.start_occ), 64'(got.start_occ));
            field_check("end_occurrences", 64'(want.end_occ), 64'(got.end_occ));
            field_check("distinct_edges", 64'(want.distinct), 64'(got.distinct));
            field_check("total_weight", 64'(want.total), 64'(got.total));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_opcode;
    logic [ACT_W-1:0]    i_act_id;
    logic [WEIGHT_W-1:0] i_weight;
    logic                i_first_of_variant;
    logic                i_last_of_variant;
    logic [ACT_W-1:0]    i_edge_target;
    logic                i_cfg_wr_en;
    logic                i_cfg_wr_data;
    logic                o_strobe;
    t_count              o_occurrences;
    t_count              o_case_occurrences;
    t_count              o_start_occurrences;
    t_count              o_end_occurrences;
    logic [TALLY_W-1:0]  o_distinct_edges;
    t_count              o_total_weight;

    follows_counts tracker;
    bit            no_gaps;
    t_readout      seen_word;

    activity_edge_stats_accumulator uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_act_id           (i_act_id),
        .i_weight           (i_weight),
        .i_first_of_variant (i_first_of_variant),
        .i_last_of_variant  (i_last_of_variant),
        .i_edge_target      (i_edge_target),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_strobe           (o_strobe),
        .o_occurrences      (o_occurrences),
        .o_case_occurrences (o_case_occurrences),
        .o_start_occurrences(o_start_occurrences),
        .o_end_occurrences  (o_end_occurrences),
        .o_distinct_edges   (o_distinct_edges),
        .o_total_weight     (o_total_weight)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result words are only valid for the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen_word = {o_occurrences, o_case_occurrences, o_start_occurrences,
                         o_end_occurrences, o_distinct_edges, o_total_weight};
            tracker.compare_readout(seen_word);
        end
    end

    // present one word after a random gap and hold it until busy is low at an edge
    task automatic issue_word(input logic [OP_W-1:0] op, input logic [ACT_W-1:0] id,
                              input logic [WEIGHT_W-1:0] w, input bit first,
                              input bit last, input logic [ACT_W-1:0] tgt);
        int gap;
        if ($urandom_range(0, 19) == 0)
            no_gaps = !no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_opcode <= op;
        i_act_id <= id;
        i_weight <= w;
        i_first_of_variant <= first;
        i_last_of_variant <= last;
        i_edge_target <= tgt;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        tracker.apply_word(op, id, w, first, last, tgt);
    endtask

    // change the edge mode once the block has gone quiet
    task automatic set_edge_mode(input bit v);
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending_readouts.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        tracker.edges_on = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // mostly a small pool so that repeats and self-loops are common
    function automatic logic [ACT_W-1:0] pick_activity();
        if ($urandom_range(0, 7) == 0)
            return ACT_W'($urandom_range(0, ACTIVITIES - 1));
        return ACT_W'($urandom_range(0, 5));
    endfunction

    task automatic issue_read();
        logic [OP_W-1:0] op;
        op = $urandom_range(0, 1) ? OP_READ_ACT : OP_READ_EDGE;
        issue_word(op, pick_activity(), $urandom, 1'($urandom), 1'($urandom),
                   pick_activity());
    endtask

    // one well-formed variant, same weight on every element
    task automatic send_variant(input int len);
        logic [WEIGHT_W-1:0] w;
        w = pick_weight();
        for (int k = 0; k < len; k++) begin
            issue_word(OP_ACCUMULATE, pick_activity(), w, k == 0, k == len - 1,
                       ACT_W'($urandom));
            if ($urandom_range(0, 5) == 0)
                issue_read();
        end
    endtask

    task automatic run_random(input int n);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = $urandom_range(1, 6);
                send_variant(len);
                done += len;
            end else if (pick < 85) begin
                issue_read();
                done++;
            end else if (pick < 95) begin
                // loose element with random marks
                issue_word(OP_ACCUMULATE, ACT_W'($urandom), $urandom, 1'($urandom),
                           1'($urandom), ACT_W'($urandom));
                done++;
            end else begin
                issue_word(OP_NONE, ACT_W'($urandom), $urandom, 1'($urandom),
                           1'($urandom), ACT_W'($urandom));
            end
        end
    endtask

    initial begin
        int waited;
        tracker = new();
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_ACCUMULATE;
        i_act_id = '0;
        i_weight = '0;
        i_first_of_variant = 1'b0;
        i_last_of_variant = 1'b0;
        i_edge_target = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fresh counters read back as zero
        issue_word(OP_READ_ACT, 0, 0, 0, 0, 0);
        issue_word(OP_READ_EDGE, 0, 0, 0, 0, 0);
        // element ahead of any first mark: pairs with activity 0, no case count
        issue_word(OP_ACCUMULATE, 5, 7, 0, 0, 0);
        // unused opcode is dropped
        issue_word(OP_NONE, 63, '1, 1, 1, 63);
        // full-weight variant with a self-loop at the top activity
        issue_word(OP_ACCUMULATE, 0, '1, 1, 0, 0);
        issue_word(OP_ACCUMULATE, 63, '1, 0, 0, 0);
        issue_word(OP_ACCUMULATE, 63, '1, 0, 0, 0);
        issue_word(OP_ACCUMULATE, 0, '1, 0, 1, 0);
        // single-element variant of zero weight
        issue_word(OP_ACCUMULATE, 63, 0, 1, 1, 0);
        // repeated edge within one variant, case counted once
        issue_word(OP_ACCUMULATE, 1, 3, 1, 0, 0);
        issue_word(OP_ACCUMULATE, 2, 3, 0, 0, 0);
        issue_word(OP_ACCUMULATE, 1, 3, 0, 0, 0);
        issue_word(OP_ACCUMULATE, 2, 3, 0, 1, 0);
        issue_word(OP_READ_ACT, 0, 0, 0, 0, 0);
        issue_word(OP_READ_ACT, 63, 0, 0, 0, 0);
        issue_word(OP_READ_ACT, 5, 0, 0, 0, 0);
        issue_word(OP_READ_ACT, 1, 0, 0, 0, 0);
        issue_word(OP_READ_ACT, 2, 0, 0, 0, 0);
        issue_word(OP_READ_EDGE, 0, 0, 0, 0, 5);
        issue_word(OP_READ_EDGE, 0, 0, 0, 0, 63);
        issue_word(OP_READ_EDGE, 63, 0, 0, 0, 63);
        issue_word(OP_READ_EDGE, 63, 0, 0, 0, 0);
        issue_word(OP_READ_EDGE, 1, 0, 0, 0, 2);
        issue_word(OP_READ_EDGE, 2, 0, 0, 0, 1);

        // self-loops only: 3->4 and 4->3 must stay uncounted
        set_edge_mode(1'b0);
        issue_word(OP_ACCUMULATE, 3, 9, 1, 0, 0);
        issue_word(OP_ACCUMULATE, 4, 9, 0, 0, 0);
        issue_word(OP_ACCUMULATE, 4, 9, 0, 0, 0);
        issue_word(OP_ACCUMULATE, 3, 9, 0, 1, 0);
        issue_word(OP_READ_EDGE, 3, 0, 0, 0, 4);
        issue_word(OP_READ_EDGE, 4, 0, 0, 0, 4);
        run_random(90);

        set_edge_mode(1'b1);
        run_random(90);
        set_edge_mode(1'b0);
        run_random(90);
        set_edge_mode(1'b1);
        run_random(90);

        @(negedge i_clk);
        start <= 1'b0;

        // drain the outstanding read-outs, then allow for the pipeline
        waited = 0;
        while (tracker.pending_readouts.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);

        if (tracker.mismatch_count == 0 && tracker.pending_readouts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/aesa_pkg.sv
hdl/aesa_ctrl.sv
hdl/aesa_datapath.sv
hdl/activity_edge_stats_accumulator.sv
test/tb_activity_edge_stats_accumulator.sv
